/* design/jpp_pkg.sv */
package jpp_pkg;

    localparam int MAX_DEPTH = 30;
    localparam int TAB_LIMIT = 30;
    localparam int DEPTH_W   = 5;
    localparam logic [DEPTH_W-1:0] DEPTH_CAP =
        (MAX_DEPTH < TAB_LIMIT) ? DEPTH_W'(MAX_DEPTH) : DEPTH_W'(TAB_LIMIT);

    localparam logic [7:0] C_SPACE  = 8'h20;
    localparam logic [7:0] C_TAB    = 8'h09;
    localparam logic [7:0] C_NL     = 8'h0A;
    localparam logic [7:0] C_CR     = 8'h0D;
    localparam logic [7:0] C_LBRACE = 8'h7B;
    localparam logic [7:0] C_RBRACE = 8'h7D;
    localparam logic [7:0] C_COLON  = 8'h3A;
    localparam logic [7:0] C_COMMA  = 8'h2C;
    localparam logic [7:0] C_QUOTE  = 8'h22;
    localparam logic [7:0] C_BSLASH = 8'h5C;
    localparam logic [7:0] C_SLASH  = 8'h2F;
    localparam logic [7:0] C_STAR   = 8'h2A;

    typedef enum logic [2:0] {
        M_NORMAL = 3'd0,
        M_STRING = 3'd1,
        M_ESC    = 3'd2,
        M_SLASH  = 3'd3,
        M_LINE   = 3'd4,
        M_BLOCK  = 3'd5,
        M_STAR   = 3'd6
    } t_mode;

    typedef enum logic [2:0] {
        S_IDLE  = 3'd0,
        S_LEAD0 = 3'd1,
        S_LEAD1 = 3'd2,
        S_TABS  = 3'd3,
        S_TAIL  = 3'd4
    } t_state;

    typedef enum logic [1:0] {
        SEL_LEAD0 = 2'd0,
        SEL_LEAD1 = 2'd1,
        SEL_TAB   = 2'd2,
        SEL_TAIL  = 2'd3
    } t_sel;

    typedef struct packed {
        logic load;
        logic emit;
        t_sel sel;
        logic last;
    } t_ctl_cmd;

    typedef struct packed {
        logic dec_any;
        logic lead_two;
        logic tabs_nz;
        logic tab_one;
        logic tail_en;
        logic out_free;
    } t_dp_stat;

endpackage

/* design/json_pretty_printer.sv */
// Flow: an accepted byte is latched into the run descriptor, and the controller then
// moves the K output bytes it causes (0 to 32) into the single output register,
// one byte per cycle while the output is not stalled; no new input byte is taken
// until the run is done. Tab runs set K for braces, commas and comment ends.
// Reset: synchronous, active low; clears depth, mode, the controller and output valid.
module json_pretty_printer
    import jpp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_run_end
);

    t_ctl_cmd cmd;
    t_dp_stat stat;

    jpp_controller u_ctl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    jpp_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_byte   (i_in_byte),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_byte  (o_out_byte),
        .o_run_end   (o_run_end)
    );

endmodule

/* design/jpp_datapath.sv */
module jpp_datapath
    import jpp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_in_byte,
    input  logic       i_out_stall,
    input  t_ctl_cmd   i_cmd,
    output t_dp_stat   o_stat,
    output logic       o_out_valid,
    output logic [7:0] o_out_byte,
    output logic       o_run_end
);

    t_mode              r_mode, n_mode;
    logic [DEPTH_W-1:0] r_depth, n_depth;

    logic [7:0]         r_lead0, r_lead1, r_tail;
    logic               r_lead_two, r_tail_en;
    logic [DEPTH_W-1:0] r_tab_cnt;

    logic               r_out_valid;
    logic [7:0]         r_out_byte;
    logic               r_out_end;

    logic               d_any, d_two, d_tab, d_tail_en, d_norm;
    logic [7:0]         d_lead0, d_lead1;
    logic [7:0]         c;
    logic [7:0]         emit_byte;

    assign c = i_in_byte;

    always_comb begin
        n_mode    = r_mode;
        n_depth   = r_depth;
        d_any     = 1'b0;
        d_two     = 1'b0;
        d_tab     = 1'b0;
        d_tail_en = 1'b0;
        d_lead0   = c;
        d_lead1   = C_NL;
        d_norm    = 1'b0;
        case (r_mode)
            M_STRING: begin
                d_any = 1'b1;
                if (c == C_BSLASH) begin
                    n_mode = M_ESC;
                end else if (c == C_QUOTE) begin
                    n_mode = M_NORMAL;
                end
            end
            M_ESC: begin
                d_any  = 1'b1;
                n_mode = M_STRING;
            end
            M_SLASH: begin
                if (c == C_SLASH) begin
                    d_any   = 1'b1;
                    d_two   = 1'b1;
                    d_lead0 = C_SLASH;
                    d_lead1 = C_SLASH;
                    n_mode  = M_LINE;
                end else if (c == C_STAR) begin
                    d_any   = 1'b1;
                    d_two   = 1'b1;
                    d_lead0 = C_SLASH;
                    d_lead1 = C_STAR;
                    n_mode  = M_BLOCK;
                end else begin
                    d_norm = 1'b1;
                end
            end
            M_LINE: begin
                d_any = 1'b1;
                if (c == C_NL) begin
                    d_tab  = 1'b1;
                    n_mode = M_NORMAL;
                end
            end
            M_BLOCK: begin
                d_any = 1'b1;
                if (c == C_STAR) begin
                    n_mode = M_STAR;
                end
            end
            M_STAR: begin
                d_any = 1'b1;
                if (c == C_SLASH) begin
                    d_two  = 1'b1;
                    d_tab  = 1'b1;
                    n_mode = M_NORMAL;
                end else if (c != C_STAR) begin
                    n_mode = M_BLOCK;
                end
            end
            default: begin
                d_norm = 1'b1;
            end
        endcase

        if (d_norm) begin
            n_mode = M_NORMAL;
            case (c)
                C_SPACE, C_TAB, C_NL, C_CR: begin
                end
                C_LBRACE: begin
                    n_depth = (r_depth < DEPTH_CAP) ? r_depth + 1'b1 : DEPTH_CAP;
                    d_any   = 1'b1;
                    d_two   = 1'b1;
                    d_tab   = 1'b1;
                end
                C_RBRACE: begin
                    n_depth   = (r_depth != '0) ? r_depth - 1'b1 : '0;
                    d_any     = 1'b1;
                    d_lead0   = C_NL;
                    d_tab     = 1'b1;
                    d_tail_en = 1'b1;
                end
                C_COLON: begin
                    d_any   = 1'b1;
                    d_two   = 1'b1;
                    d_lead1 = C_SPACE;
                end
                C_COMMA: begin
                    d_any = 1'b1;
                    d_two = 1'b1;
                    d_tab = 1'b1;
                end
                C_QUOTE: begin
                    d_any  = 1'b1;
                    n_mode = M_STRING;
                end
                C_SLASH: begin
                    n_mode = M_SLASH;
                end
                default: begin
                    d_any = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_NORMAL;
            r_depth <= '0;
        end else if (i_cmd.load) begin
            r_mode  <= n_mode;
            r_depth <= n_depth;
        end
    end

    // latch the run descriptor for the controller to walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_lead0    <= d_lead0;
            r_lead1    <= d_lead1;
            r_lead_two <= d_two;
            r_tail_en  <= d_tail_en;
            r_tail     <= C_RBRACE;
            r_tab_cnt  <= d_tab ? n_depth : '0;
        end else if (i_cmd.emit && i_cmd.sel == SEL_TAB) begin
            r_tab_cnt  <= r_tab_cnt - 1'b1;
        end
    end

    always_comb begin
        case (i_cmd.sel)
            SEL_LEAD0: emit_byte = r_lead0;
            SEL_LEAD1: emit_byte = r_lead1;
            SEL_TAB:   emit_byte = C_TAB;
            SEL_TAIL:  emit_byte = r_tail;
            default:   emit_byte = r_lead0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_byte <= emit_byte;
            r_out_end  <= i_cmd.last;
        end
    end

    assign o_stat.dec_any  = d_any;
    assign o_stat.lead_two = r_lead_two;
    assign o_stat.tabs_nz  = (r_tab_cnt != '0);
    assign o_stat.tab_one  = (r_tab_cnt == DEPTH_W'(1));
    assign o_stat.tail_en  = r_tail_en;
    assign o_stat.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_run_end   = r_out_end;

endmodule

/* design/jpp_controller.sv */
module jpp_controller
    import jpp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_dp_stat i_stat,
    output logic     o_in_stall,
    output t_ctl_cmd o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_stat.dec_any) begin
                        n_state = S_LEAD0;
                    end
                end
            end
            S_LEAD0: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = SEL_LEAD0;
                    if (i_stat.lead_two) begin
                        n_state = S_LEAD1;
                    end else if (i_stat.tabs_nz) begin
                        n_state = S_TABS;
                    end else if (i_stat.tail_en) begin
                        n_state = S_TAIL;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_LEAD1: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = SEL_LEAD1;
                    if (i_stat.tabs_nz) begin
                        n_state = S_TABS;
                    end else if (i_stat.tail_en) begin
                        n_state = S_TAIL;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_TABS: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = SEL_TAB;
                    if (i_stat.tab_one) begin
                        n_state = i_stat.tail_en ? S_TAIL : S_IDLE;
                    end
                end
            end
            S_TAIL: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = SEL_TAIL;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // flag the final beat of the run
        o_cmd.last = o_cmd.emit && (n_state == S_IDLE);
    end

endmodule

/* design/jpp_checker.sv */
module jpp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic [7:0] i_in_byte,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_out_byte,
    input logic       o_run_end
);

    // hold a stalled output beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_out_byte) && $stable(o_run_end))
        else $error("stalled output beat changed");

    // no new byte may enter while a run is still unfinished
    a_run_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_run_end |-> o_in_stall)
        else $error("input open in the middle of a run");

    // a run continues without a gap once a middle beat is taken
    a_run_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_run_end |=> o_out_valid)
        else $error("gap inside an output run");

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("outputs not idle after reset");

endmodule

bind json_pretty_printer jpp_checker u_chk (.*);

/* bench/json_pretty_printer_tb.sv */
module json_pretty_printer_tb;
    import jpp_pkg::*;

    localparam int RAND_ITEMS  = 360;
    localparam int N_PHASES    = 3;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int N_ROWS      = 27;

    typedef struct packed {
        logic [7:0] b;
        logic       last;
    } t_beat;

    // one directed source byte; known rows carry their output typed in (two bytes at most)
    typedef struct packed {
        logic [7:0] src;
        logic       known;
        logic [1:0] n;
        logic [7:0] e0;
        logic [7:0] e1;
    } t_row;

    typedef enum int {
        TK_OPEN, TK_CLOSE, TK_COMMA, TK_COLON, TK_SPACE, TK_STRING,
        TK_WORD, TK_LINE, TK_BLOCK, TK_SLASH, TK_NOISE, TK_NEST
    } t_token;

    logic       i_clk;
    logic       i_rst_n    = 1'b0;
    logic       src_valid  = 1'b0;
    logic [7:0] src_byte   = 8'h00;
    logic       sink_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic       o_run_end;

    json_pretty_printer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (src_valid),
        .o_in_stall  (o_in_stall),
        .i_in_byte   (src_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (sink_stall),
        .o_out_byte  (o_out_byte),
        .o_run_end   (o_run_end)
    );

    t_row dir_rows [N_ROWS] = '{
        '{"a",      1'b1, 2'd1, "a",      8'h00},
        '{8'h00,    1'b1, 2'd1, 8'h00,    8'h00},
        '{8'hFF,    1'b1, 2'd1, 8'hFF,    8'h00},
        '{C_SPACE,  1'b1, 2'd0, 8'h00,    8'h00},
        '{C_COLON,  1'b1, 2'd2, C_COLON,  C_SPACE},
        '{C_RBRACE, 1'b1, 2'd2, C_NL,     C_RBRACE},
        '{C_LBRACE, 1'b0, 2'd0, 8'h00,    8'h00},
        '{C_QUOTE,  1'b1, 2'd1, C_QUOTE,  8'h00},
        '{C_BSLASH, 1'b1, 2'd1, C_BSLASH, 8'h00},
        '{C_QUOTE,  1'b1, 2'd1, C_QUOTE,  8'h00},
        '{C_NL,     1'b1, 2'd1, C_NL,     8'h00},
        '{C_QUOTE,  1'b1, 2'd1, C_QUOTE,  8'h00},
        '{C_COMMA,  1'b0, 2'd0, 8'h00,    8'h00},
        '{C_SLASH,  1'b1, 2'd0, 8'h00,    8'h00},
        '{"q",      1'b1, 2'd1, "q",      8'h00},
        '{C_SLASH,  1'b1, 2'd0, 8'h00,    8'h00},
        '{C_SLASH,  1'b1, 2'd2, C_SLASH,  C_SLASH},
        '{C_CR,     1'b1, 2'd1, C_CR,     8'h00},
        '{C_NL,     1'b0, 2'd0, 8'h00,    8'h00},
        '{C_SLASH,  1'b1, 2'd0, 8'h00,    8'h00},
        '{C_STAR,   1'b1, 2'd2, C_SLASH,  C_STAR},
        '{C_SLASH,  1'b1, 2'd1, C_SLASH,  8'h00},
        '{C_STAR,   1'b1, 2'd1, C_STAR,   8'h00},
        '{C_SLASH,  1'b0, 2'd0, 8'h00,    8'h00},
        '{C_SLASH,  1'b1, 2'd0, 8'h00,    8'h00},
        '{C_RBRACE, 1'b0, 2'd0, 8'h00,    8'h00},
        '{C_RBRACE, 1'b1, 2'd2, C_NL,     C_RBRACE}
    };

    // formatter state as the printer should hold it
    t_mode       fmt_mode  = M_NORMAL;
    logic [4:0]  fmt_depth = '0;
    logic [7:0]  run_q[$];
    t_beat       pending[$];

    bit          src_idle_en  = 1'b1;
    bit          sink_idle_en = 1'b1;
    int unsigned sink_hold    = 0;
    int unsigned n_src        = 0;
    int unsigned n_out        = 0;
    int unsigned mismatches   = 0;
    int unsigned deepest      = 0;
    int unsigned n_line_cmt   = 0;
    int unsigned n_block_cmt  = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic void emit(input logic [7:0] b);
        if (run_q.size() < 32) run_q.push_back(b);
    endfunction

    function automatic void emit_indent();
        for (int i = 0; i < fmt_depth; i++) emit(C_TAB);
    endfunction

    function automatic void format_plain(input logic [7:0] c);
        fmt_mode = M_NORMAL;
        case (c)
            C_SPACE, C_TAB, C_NL, C_CR: ;
            C_LBRACE: begin
                if (fmt_depth < DEPTH_CAP) fmt_depth++;
                else fmt_depth = DEPTH_CAP;
                if (fmt_depth > deepest) deepest = fmt_depth;
                emit(C_LBRACE);
                emit(C_NL);
                emit_indent();
            end
            C_RBRACE: begin
                if (fmt_depth != 0) fmt_depth--;
                emit(C_NL);
                emit_indent();
                emit(C_RBRACE);
            end
            C_COLON: begin
                emit(C_COLON);
                emit(C_SPACE);
            end
            C_COMMA: begin
                emit(C_COMMA);
                emit(C_NL);
                emit_indent();
            end
            C_QUOTE: begin
                emit(C_QUOTE);
                fmt_mode = M_STRING;
            end
            C_SLASH: fmt_mode = M_SLASH;
            default: emit(c);
        endcase
    endfunction

    // work out the formatted run that one source byte causes
    function automatic void predict_format(input logic [7:0] c);
        run_q.delete();
        case (fmt_mode)
            M_STRING: begin
                emit(c);
                if (c == C_BSLASH) fmt_mode = M_ESC;
                else if (c == C_QUOTE) fmt_mode = M_NORMAL;
            end
            M_ESC: begin
                emit(c);
                fmt_mode = M_STRING;
            end
            M_SLASH: begin
                if (c == C_SLASH) begin
                    emit(C_SLASH);
                    emit(C_SLASH);
                    fmt_mode = M_LINE;
                    n_line_cmt++;
                end else if (c == C_STAR) begin
                    emit(C_SLASH);
                    emit(C_STAR);
                    fmt_mode = M_BLOCK;
                    n_block_cmt++;
                end else begin
                    format_plain(c);
                end
            end
            M_LINE: begin
                emit(c);
                if (c == C_NL) begin
                    emit_indent();
                    fmt_mode = M_NORMAL;
                end
            end
            M_BLOCK: begin
                emit(c);
                if (c == C_STAR) fmt_mode = M_STAR;
            end
            M_STAR: begin
                emit(c);
                if (c == C_SLASH) begin
                    emit(C_NL);
                    emit_indent();
                    fmt_mode = M_NORMAL;
                end else if (c != C_STAR) begin
                    fmt_mode = M_BLOCK;
                end
            end
            default: format_plain(c);
        endcase
    endfunction

    function automatic void push_expect(input logic [7:0] b, input logic last);
        t_beat e;
        e.b    = b;
        e.last = last;
        pending.push_back(e);
    endfunction

    function automatic void queue_run();
        foreach (run_q[i]) push_expect(run_q[i], i == run_q.size() - 1);
    endfunction

    function automatic void check_beat(input logic [7:0] b, input logic last);
        t_beat want;
        n_out++;
        if (pending.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected beat out_byte=%02h run_end=%0b", $time, b, last);
            return;
        end
        want = pending.pop_front();
        if (b !== want.b) begin
            mismatches++;
            $display("%0t: out_byte expected %02h actual %02h", $time, want.b, b);
        end
        if (last !== want.last) begin
            mismatches++;
            $display("%0t: run_end expected %0b actual %0b", $time, want.last, last);
        end
    endfunction

    // output side: take a beat, then maybe hold stall for a while
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (sink_hold != 0) begin
                sink_hold--;
                if (sink_hold == 0) sink_stall <= 1'b0;
            end else if (o_out_valid && !sink_stall) begin
                check_beat(o_out_byte, o_run_end);
                if ($urandom_range(0, 39) == 0) sink_idle_en = !sink_idle_en;
                sink_hold = sink_idle_en ? $urandom_range(0, 17) : 0;
                if (sink_hold != 0) sink_stall <= 1'b1;
            end
        end
    end

    task automatic send_beat(input logic [7:0] b);
        int unsigned gap;
        gap = src_idle_en ? $urandom_range(0, 17) : 0;
        if (gap != 0) begin
            src_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        src_valid <= 1'b1;
        src_byte  <= b;
        do @(posedge i_clk); while (o_in_stall);
        n_src++;
    endtask

    task automatic feed(input logic [7:0] b);
        send_beat(b);
        predict_format(b);
        queue_run();
    endtask

    task automatic hold_until_drained();
        src_valid <= 1'b0;
        do @(posedge i_clk); while (pending.size() != 0);
    endtask

    function automatic logic [7:0] word_char();
        if ($urandom_range(0, 1) != 0) return 8'h30 + 8'($urandom_range(0, 9));
        return 8'h61 + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] text_char();
        if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(8'h20, 8'h7E));
    endfunction

    // push past the depth cap and back below zero
    task automatic nest_burst();
        int unsigned n;
        n = $urandom_range(31, 33);
        repeat (n) feed(C_LBRACE);
        feed(C_COMMA);
        repeat (n + 1) feed(C_RBRACE);
    endtask

    task automatic send_token(input t_token tk);
        logic [7:0] c;
        case (tk)
            TK_OPEN:  feed(C_LBRACE);
            TK_CLOSE: feed(C_RBRACE);
            TK_COMMA: feed(C_COMMA);
            TK_COLON: feed(C_COLON);
            TK_SPACE: begin
                repeat ($urandom_range(1, 3)) begin
                    case ($urandom_range(0, 3))
                        0: feed(C_SPACE);
                        1: feed(C_TAB);
                        2: feed(C_NL);
                        default: feed(C_CR);
                    endcase
                end
            end
            TK_STRING: begin
                feed(C_QUOTE);
                repeat ($urandom_range(0, 6)) begin
                    if ($urandom_range(0, 4) == 0) begin
                        feed(C_BSLASH);
                        feed(8'($urandom_range(0, 255)));
                    end else begin
                        feed(text_char());
                    end
                end
                feed(C_QUOTE);
            end
            TK_WORD: repeat ($urandom_range(1, 5)) feed(word_char());
            TK_LINE: begin
                feed(C_SLASH);
                feed(C_SLASH);
                repeat ($urandom_range(0, 8)) begin
                    c = text_char();
                    feed(c == C_NL ? C_CR : c);
                end
                feed(C_NL);
            end
            TK_BLOCK: begin
                feed(C_SLASH);
                feed(C_STAR);
                repeat ($urandom_range(0, 8))
                    feed($urandom_range(0, 2) == 0 ? C_STAR : text_char());
                feed(C_STAR);
                feed(C_SLASH);
            end
            TK_SLASH: begin
                feed(C_SLASH);
                feed(text_char());
            end
            TK_NOISE: feed(8'($urandom_range(0, 255)));
            default:  nest_burst();
        endcase
    endtask

    function automatic t_token pick_token();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 12) return TK_OPEN;
        if (r < 22) return TK_CLOSE;
        if (r < 32) return TK_COMMA;
        if (r < 40) return TK_COLON;
        if (r < 48) return TK_SPACE;
        if (r < 66) return TK_STRING;
        if (r < 76) return TK_WORD;
        if (r < 82) return TK_LINE;
        if (r < 88) return TK_BLOCK;
        if (r < 92) return TK_SLASH;
        if (r < 99) return TK_NOISE;
        return TK_NEST;
    endfunction

    initial begin : watchdog
        int unsigned cyc;
        cyc = 0;
        while (cyc < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cyc++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin : stimulus
        int unsigned n_dir;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            send_beat(dir_rows[k].src);
            predict_format(dir_rows[k].src);
            if (!dir_rows[k].known) begin
                queue_run();
            end else begin
                if (dir_rows[k].n != 0) push_expect(dir_rows[k].e0, dir_rows[k].n == 1);
                if (dir_rows[k].n == 2) push_expect(dir_rows[k].e1, 1'b1);
            end
        end
        n_dir = n_src;
        hold_until_drained();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (ph == 0) nest_burst();
            while (n_src - n_dir < RAND_ITEMS * (ph + 1) / N_PHASES) begin
                if ($urandom_range(0, 19) == 0) src_idle_en = !src_idle_en;
                send_token(pick_token());
            end
            // let the output side catch up completely between phases
            hold_until_drained();
        end

        repeat (64) @(posedge i_clk);

        $display("Fed %0d source bytes (%0d directed), checked %0d formatted bytes.",
                 n_src, n_dir, n_out);
        $display("Deepest nesting %0d, %0d line and %0d block comments, %0d mismatches.",
                 deepest, n_line_cmt, n_block_cmt, mismatches);
        if (mismatches == 0 && pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* sim.f */
design/jpp_pkg.sv
design/jpp_datapath.sv
design/jpp_controller.sv
design/json_pretty_printer.sv
design/jpp_checker.sv
bench/json_pretty_printer_tb.sv
